// ===== hw/rtl/spmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmm_pkg
// Shared sizes, function codes and fixed-point limits for the sparse x dense
// matrix product block.
// ----------------------------------------------------------------------------
package spmm_pkg;

   localparam int MAX_B_ROWS = 1024;
   localparam int MAX_FEAT   = 64;
   localparam int LANES      = 4;
   localparam int GROUPS     = MAX_FEAT / LANES;

   localparam int B_ROW_W = $clog2(MAX_B_ROWS);
   localparam int FEAT_W  = $clog2(MAX_FEAT);
   localparam int LANE_W  = $clog2(LANES);
   localparam int GRP_W   = FEAT_W - LANE_W;
   localparam int B_DEPTH = MAX_B_ROWS * GROUPS;

   // fixed field widths
   localparam int FUNC_W    = 2;
   localparam int ROW_IN_W  = 10;
   localparam int COL_IN_W  = 6;
   localparam int LEN_W     = 7;
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 32;
   localparam int ACC_W     = 40;
   localparam int OUT_W     = 32;

   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_END_ROW = 2'd2;

   localparam logic [LEN_W-1:0] NUM_FEAT_RESET = LEN_W'(MAX_FEAT);

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef logic [LANES-1:0][ACC_W-1:0]  acc_row_type;
   typedef logic [LANES-1:0][DATA_W-1:0] b_row_type;

endpackage

// ===== hw/rtl/csr_sparse_dense_matmul_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_dense_matmul_top
// load request: busy stays low; nonzero with n features: busy until its
// ceil(n/4) groups are written back, four accumulators read, updated and
// written back a cycle; end of row: busy until its n results are out, one
// result a cycle; the receiver cannot stall results
// sync reset clears control, zeroes the sums via row valid bits and sets the
// feature count to 64; B stays undefined until written
// ----------------------------------------------------------------------------
module csr_sparse_dense_matmul_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [spmm_pkg::LEN_W-1:0]           csr_wdata,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [spmm_pkg::FUNC_W-1:0]          req_func,
   input  logic [spmm_pkg::ROW_IN_W-1:0]        req_b_row,
   input  logic [spmm_pkg::COL_IN_W-1:0]        req_b_col,
   input  logic signed [spmm_pkg::DATA_W-1:0]   req_b_value,
   input  logic [spmm_pkg::ROW_IN_W-1:0]        req_col_index,
   input  logic signed [spmm_pkg::DATA_W-1:0]   req_a_value,
   output logic                                 rsp_strobe,
   output logic [spmm_pkg::COL_IN_W-1:0]        rsp_feature_index,
   output logic signed [spmm_pkg::OUT_W-1:0]    rsp_out_value,
   output logic                                 rsp_last,
   output logic                                 rsp_saturated
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   localparam int LANES  = spmm_pkg::LANES;
   localparam int LANE_W = spmm_pkg::LANE_W;
   localparam int GRP_W  = spmm_pkg::GRP_W;
   localparam int FEAT_W = spmm_pkg::FEAT_W;
   localparam int LEN_W  = spmm_pkg::LEN_W;
   localparam int ACC_W  = spmm_pkg::ACC_W;
   localparam int OUT_W  = spmm_pkg::OUT_W;

   // control registers
   state_type                        state_ff;
   logic [LEN_W-1:0]                 num_feat_ff;
   logic [FEAT_W-1:0]                cnt_ff;
   logic [spmm_pkg::GROUPS-1:0]      row_valid_ff;
   logic                             s1_mac_ff;
   logic                             s1_emit_ff;
   logic                             s2_mac_ff;
   logic                             rsp_strobe_ff;

   // request payload
   logic [spmm_pkg::B_ROW_W-1:0]     row_ff;
   logic signed [spmm_pkg::DATA_W-1:0] a_ff;

   // memories and their read registers
   spmm_pkg::b_row_type              b_mem [spmm_pkg::B_DEPTH];
   spmm_pkg::acc_row_type            acc_mem [spmm_pkg::GROUPS];
   spmm_pkg::b_row_type              b_rd_ff;
   spmm_pkg::acc_row_type            acc_rd_ff;
   logic                             acc_ok_ff;

   // pipeline payload
   logic [GRP_W-1:0]                 s1_grp_ff;
   logic [LANES-1:0]                 s1_mask_ff;
   logic [FEAT_W-1:0]                s1_feat_ff;
   logic                             s1_last_ff;
   logic [GRP_W-1:0]                 s2_grp_ff;
   logic [LANES-1:0]                 s2_mask_ff;
   logic [LANES-1:0][spmm_pkg::PROD_W-1:0] prod_ff;
   spmm_pkg::acc_row_type            old_ff;

   logic [FEAT_W-1:0]                rsp_feat_ff;
   logic [OUT_W-1:0]                 rsp_value_ff;
   logic                             rsp_last_ff;
   logic                             rsp_sat_ff;

   // combinational
   logic                             accept;
   logic [LEN_W-1:0]                 len;
   logic [FEAT_W-1:0]                last_elem;
   logic [GRP_W-1:0]                 last_grp;
   logic                             mac_issue;
   logic                             emit_issue;
   logic [GRP_W-1:0]                 rd_grp;
   logic [LANES-1:0]                 lane_mask;
   logic                             b_we;
   logic [FEAT_W-1:0]                wr_col;
   logic [spmm_pkg::B_ROW_W+GRP_W-1:0] b_wr_addr;
   logic [spmm_pkg::B_ROW_W+GRP_W-1:0] b_rd_addr;
   spmm_pkg::acc_row_type            acc_old;
   spmm_pkg::acc_row_type            acc_new;
   logic [LANES-1:0][spmm_pkg::PROD_W-1:0] prod;
   logic [ACC_W-1:0]                 emit_acc;
   logic                             emit_sat;
   logic [OUT_W-1:0]                 emit_value;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign mac_issue  = (state_ff == ST_MAC);
   assign emit_issue = (state_ff == ST_EMIT);

   // a feature count of 0 acts as 1, anything above the maximum as the maximum
   always_comb begin
      if (num_feat_ff == '0) begin
         len = LEN_W'(1);
      end else if (num_feat_ff > LEN_W'(spmm_pkg::MAX_FEAT)) begin
         len = LEN_W'(spmm_pkg::MAX_FEAT);
      end else begin
         len = num_feat_ff;
      end
   end

   assign last_elem = FEAT_W'(len - LEN_W'(1));
   assign last_grp  = last_elem[FEAT_W-1:LANE_W];
   assign rd_grp    = mac_issue ? cnt_ff[GRP_W-1:0] : cnt_ff[FEAT_W-1:LANE_W];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_mask[l] = (LEN_W'({rd_grp, LANE_W'(l)}) < len);
      end
   end

   // B write port
   assign wr_col    = FEAT_W'(req_b_col);
   assign b_we      = accept && (req_func == spmm_pkg::FUNC_LOAD) &&
                      (32'(req_b_row) < 32'(spmm_pkg::MAX_B_ROWS)) &&
                      (32'(req_b_col) < 32'(spmm_pkg::MAX_FEAT));
   assign b_wr_addr = {spmm_pkg::B_ROW_W'(req_b_row), wr_col[FEAT_W-1:LANE_W]};
   assign b_rd_addr = {row_ff, cnt_ff[GRP_W-1:0]};

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (b_we && (wr_col[LANE_W-1:0] == LANE_W'(l))) begin
            b_mem[b_wr_addr][l] <= req_b_value;
         end
      end
      b_rd_ff <= b_mem[b_rd_addr];
   end

   // accumulator memory: read one row at issue, write it back from stage s2
   always_ff @(posedge clock) begin
      if (s2_mac_ff) begin
         acc_mem[s2_grp_ff] <= acc_new;
      end
      acc_rd_ff <= acc_mem[rd_grp];
      acc_ok_ff <= row_valid_ff[rd_grp];
   end

   assign acc_old = acc_ok_ff ? acc_rd_ff : '0;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod[l] = spmm_pkg::PROD_W'($signed(a_ff) * $signed(b_rd_ff[l]));
      end
   end

   // add with saturation at the accumulator limits; lanes past len keep their value
   always_comb begin
      logic [ACC_W:0] sum;
      for (int l = 0; l < LANES; l++) begin
         sum = {old_ff[l][ACC_W-1], old_ff[l]} +
               (ACC_W+1)'($signed(prod_ff[l]));
         if (!s2_mask_ff[l]) begin
            acc_new[l] = old_ff[l];
         end else if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_new[l] = sum[ACC_W] ? spmm_pkg::ACC_MIN : spmm_pkg::ACC_MAX;
         end else begin
            acc_new[l] = sum[ACC_W-1:0];
         end
      end
   end

   // output element: clip the 40-bit sum to 32 bits
   assign emit_acc   = acc_old[s1_feat_ff[LANE_W-1:0]];
   assign emit_sat   = !((&emit_acc[ACC_W-1:OUT_W-1]) || !(|emit_acc[ACC_W-1:OUT_W-1]));
   assign emit_value = emit_sat ? (emit_acc[ACC_W-1] ? spmm_pkg::OUT_MIN : spmm_pkg::OUT_MAX)
                                : emit_acc[OUT_W-1:0];

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= spmm_pkg::B_ROW_W'(req_col_index);
         a_ff   <= req_a_value;
      end
      s1_grp_ff  <= rd_grp;
      s1_mask_ff <= lane_mask;
      s1_feat_ff <= cnt_ff;
      s1_last_ff <= (cnt_ff == last_elem);
      s2_grp_ff  <= s1_grp_ff;
      s2_mask_ff <= s1_mask_ff;
      prod_ff    <= prod;
      old_ff     <= acc_old;
      if (s1_emit_ff) begin
         rsp_feat_ff  <= s1_feat_ff;
         rsp_value_ff <= emit_value;
         rsp_last_ff  <= s1_last_ff;
         rsp_sat_ff   <= emit_sat;
      end
   end

   // state machine and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_feat_ff   <= spmm_pkg::NUM_FEAT_RESET;
         cnt_ff        <= '0;
         row_valid_ff  <= '0;
         s1_mac_ff     <= 1'b0;
         s1_emit_ff    <= 1'b0;
         s2_mac_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            num_feat_ff <= csr_wdata;
         end
         s1_mac_ff     <= mac_issue;
         s1_emit_ff    <= emit_issue;
         s2_mac_ff     <= s1_mac_ff;
         rsp_strobe_ff <= s1_emit_ff;
         if (s2_mac_ff) begin
            row_valid_ff[s2_grp_ff] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  case (req_func)
                     spmm_pkg::FUNC_NONZERO: begin
                        if (32'(req_col_index) < 32'(spmm_pkg::MAX_B_ROWS)) begin
                           state_ff <= ST_MAC;
                        end
                     end
                     spmm_pkg::FUNC_END_ROW: begin
                        state_ff <= ST_EMIT;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_MAC: begin
               cnt_ff <= cnt_ff + FEAT_W'(1);
               if (cnt_ff[GRP_W-1:0] == last_grp) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_EMIT: begin
               cnt_ff <= cnt_ff + FEAT_W'(1);
               if (cnt_ff == last_elem) begin
                  // last read issued: the row is cleared for the next one
                  row_valid_ff <= '0;
                  state_ff     <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // hold off new requests until write-back and output are done
               if (!s1_mac_ff && !s1_emit_ff && !s2_mac_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_feature_index = spmm_pkg::COL_IN_W'(rsp_feat_ff);
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // checks
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a busy period");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> (rsp_feat_ff == last_elem))
      else $error("last flag on the wrong feature");

   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      (s1_mac_ff || s1_emit_ff || s2_mac_ff) |-> busy)
      else $error("pipeline active while idle");

   a_no_row_clash: assert property (@(posedge clock) disable iff (reset)
      (s2_mac_ff && mac_issue) |-> (s2_grp_ff != rd_grp))
      else $error("accumulator row read while its write-back is pending");

endmodule
